// ----- rtl/tom_pkg.sv -----
package tom_pkg;

  // Event kinds carried by event_kind.
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_TICK    = 2'd2;

  // Commands reported in action.
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRIGGER = 2'd0;
  localparam logic [1:0] REG_MODCODE = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] TRIGGER_RST = 16'd0;
  localparam logic [15:0] MODCODE_RST = 16'd225;
  localparam logic [15:0] HOLD_RST    = 16'd200;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Reported mode codes.
  localparam logic [2:0] MCODE_IDLE        = 3'd0;
  localparam logic [2:0] MCODE_HELD_UNUSED = 3'd1;
  localparam logic [2:0] MCODE_HELD_USED   = 3'd2;
  localparam logic [2:0] MCODE_QUEUED      = 3'd3;
  localparam logic [2:0] MCODE_QUEUED_USED = 3'd4;

  // One-shot state machine, one-hot.
  typedef enum logic [4:0] {
    MODE_IDLE        = 5'b00001,
    MODE_HELD_UNUSED = 5'b00010,
    MODE_HELD_USED   = 5'b00100,
    MODE_QUEUED      = 5'b01000,
    MODE_QUEUED_USED = 5'b10000
  } mode_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] mod_code;
    logic        timed_out;
    logic [2:0]  mode;
  } result_t;

  // Map the one-hot state onto the reported mode code.
  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      MODE_IDLE:        c = MCODE_IDLE;
      MODE_HELD_UNUSED: c = MCODE_HELD_UNUSED;
      MODE_HELD_USED:   c = MCODE_HELD_USED;
      MODE_QUEUED:      c = MCODE_QUEUED;
      MODE_QUEUED_USED: c = MCODE_QUEUED_USED;
      default:          c = MCODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/tom_core.sv -----
module tom_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                step,
  input  logic [1:0]          event_kind,
  input  logic [15:0]         keycode,
  input  logic                is_cancel,
  input  logic                is_ignored,
  output tom_pkg::result_t    result
);

  logic [15:0]    trigger_keycode;
  logic [15:0]    modifier_code;
  logic [15:0]    hold_term;
  logic [15:0]    timeout_term;

  tom_pkg::mode_t os_mode, os_mode_next;
  logic [15:0]    hold_ticks, hold_ticks_next;
  logic [15:0]    queue_ticks, queue_ticks_next;
  logic           timeout_armed, timeout_armed_next;

  logic [1:0]     act;
  logic           tout;
  logic [15:0]    hold_inc;
  logic [15:0]    queue_inc;
  logic           is_trigger;
  logic           queued_any;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_keycode <= tom_pkg::TRIGGER_RST;
      modifier_code   <= tom_pkg::MODCODE_RST;
      hold_term       <= tom_pkg::HOLD_RST;
      timeout_term    <= tom_pkg::TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tom_pkg::REG_TRIGGER: trigger_keycode <= cfg_data;
        tom_pkg::REG_MODCODE: modifier_code   <= cfg_data;
        tom_pkg::REG_HOLD:    hold_term       <= cfg_data;
        tom_pkg::REG_TIMEOUT: timeout_term    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating tick counters and key classification.
  assign hold_inc   = (hold_ticks == tom_pkg::TICK_MAX) ? hold_ticks : hold_ticks + 16'd1;
  assign queue_inc  = (queue_ticks == tom_pkg::TICK_MAX) ? queue_ticks : queue_ticks + 16'd1;
  assign is_trigger = (keycode == trigger_keycode);
  assign queued_any = (os_mode == tom_pkg::MODE_QUEUED) ||
                      (os_mode == tom_pkg::MODE_QUEUED_USED);

  // Next state and command for one event.
  always_comb begin
    os_mode_next       = os_mode;
    hold_ticks_next    = hold_ticks;
    queue_ticks_next   = queue_ticks;
    timeout_armed_next = timeout_armed;
    act                = tom_pkg::ACT_NONE;
    tout               = 1'b0;
    case (event_kind)
      tom_pkg::EV_TICK: begin
        hold_ticks_next  = hold_inc;
        queue_ticks_next = queue_inc;
        if (timeout_armed && queued_any && (queue_inc > timeout_term)) begin
          os_mode_next       = tom_pkg::MODE_IDLE;
          act                = tom_pkg::ACT_RELEASE;
          timeout_armed_next = 1'b0;
          tout               = 1'b1;
        end
      end
      tom_pkg::EV_PRESS: begin
        if (is_trigger) begin
          if (os_mode == tom_pkg::MODE_IDLE) act = tom_pkg::ACT_PRESS;
          os_mode_next    = tom_pkg::MODE_HELD_UNUSED;
          hold_ticks_next = '0;
        end else if (is_cancel && (os_mode != tom_pkg::MODE_IDLE)) begin
          os_mode_next       = tom_pkg::MODE_IDLE;
          act                = tom_pkg::ACT_RELEASE;
          timeout_armed_next = 1'b0;
        end else if (!is_ignored) begin
          if (os_mode == tom_pkg::MODE_HELD_UNUSED) begin
            os_mode_next = tom_pkg::MODE_HELD_USED;
          end else if (os_mode == tom_pkg::MODE_QUEUED) begin
            os_mode_next       = tom_pkg::MODE_QUEUED_USED;
            timeout_armed_next = 1'b0;
          end
        end
      end
      tom_pkg::EV_RELEASE: begin
        if (is_trigger) begin
          if (hold_ticks > hold_term) begin
            os_mode_next = tom_pkg::MODE_IDLE;
            act          = tom_pkg::ACT_RELEASE;
          end else if (os_mode == tom_pkg::MODE_HELD_UNUSED) begin
            os_mode_next       = tom_pkg::MODE_QUEUED;
            queue_ticks_next   = '0;
            timeout_armed_next = 1'b1;
          end else if (os_mode == tom_pkg::MODE_HELD_USED) begin
            os_mode_next = tom_pkg::MODE_IDLE;
            act          = tom_pkg::ACT_RELEASE;
          end
        end else if (!is_ignored && (os_mode == tom_pkg::MODE_QUEUED_USED)) begin
          os_mode_next = tom_pkg::MODE_IDLE;
          act          = tom_pkg::ACT_RELEASE;
        end
      end
      default: ;
    endcase
  end

  // Result of the event being accepted.
  always_comb begin
    result.action    = act;
    result.mod_code  = (act != tom_pkg::ACT_NONE) ? modifier_code : 16'd0;
    result.timed_out = tout;
    result.mode      = tom_pkg::mode_code(os_mode_next);
  end

  // State registers advance once per accepted event.
  always_ff @(posedge clk) begin
    if (rst) begin
      os_mode       <= tom_pkg::MODE_IDLE;
      hold_ticks    <= '0;
      queue_ticks   <= '0;
      timeout_armed <= 1'b0;
    end else if (step) begin
      os_mode       <= os_mode_next;
      hold_ticks    <= hold_ticks_next;
      queue_ticks   <= queue_ticks_next;
      timeout_armed <= timeout_armed_next;
    end
  end

endmodule

// ----- rtl/timed_oneshot_modifier.sv -----
// Sticky one-shot modifier controller with hold and queue timeouts.
// Input channel (in_valid / in_stall): one transaction per key press, key
// release or time tick, with the key code and the upstream cancel and
// ignore flags. Every input transaction produces exactly one result.
// Output channel (out_valid / out_stall): action (none, press or release),
// the modifier code it applies to, a timeout flag and the new mode.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// cfg_index selects trigger key, modifier code, hold term or timeout term.
// The state machine updates at the accepting edge; the result is registered
// at that edge in the output register, or in the skid register if stalled.
// Throughput is one transaction per cycle while in_stall is low; the state
// update is the only loop. A skid register lets one more transaction in
// while the output is stalled; in_stall rises only when it is full.
// Synchronous reset clears the state to idle, both tick counters to zero,
// the configuration to its defaults and empties the output stage.
module timed_oneshot_modifier (
  input  logic        clk,
  input  logic        rst,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  event_kind,
  input  logic [15:0] keycode,
  input  logic        is_cancel,
  input  logic        is_ignored,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [15:0] mod_code,
  output logic        timed_out,
  output logic [2:0]  mode
);

  tom_pkg::result_t step_result;
  tom_pkg::result_t out_q;
  tom_pkg::result_t skid_q;
  logic             skid_valid;
  logic             in_accept;
  logic             out_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_pop   = out_valid && !out_stall;

  tom_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (in_accept),
    .event_kind (event_kind),
    .keycode    (keycode),
    .is_cancel  (is_cancel),
    .is_ignored (is_ignored),
    .result     (step_result)
  );

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_accept) begin
        out_q     <= step_result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_accept) begin
      skid_q     <= step_result;
      skid_valid <= 1'b1;
    end
  end

  assign action    = out_q.action;
  assign mod_code  = out_q.mod_code;
  assign timed_out = out_q.timed_out;
  assign mode      = out_q.mode;

endmodule
